// ===== rtl/smcs_pkg.sv =====
// Package with types, constants and codes for the scan match candidate scorer.
`timescale 1ns / 1ps
package smcs_pkg;

  localparam int MAP_DIM    = 256;
  localparam int MAX_POINTS = 1024;
  localparam int CELL_AW    = $clog2(MAP_DIM);
  localparam int GRID_AW    = 2 * CELL_AW;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_AW + 1;
  localparam int SUM_W      = CNT_W + 16;

  localparam logic [15:0] UNKNOWN_CELL = 16'd16384;
  localparam logic [15:0] ONE_Q15      = 16'd32768;

  typedef enum logic [1:0] {
    ACT_WRITE_CELL = 2'd0,
    ACT_APPEND_PT  = 2'd1,
    ACT_CLEAR_SCAN = 2'd2,
    ACT_SCORE      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH  = 3'd0,
    REG_MAP_HEIGHT = 3'd1,
    REG_LEVEL      = 3'd2,
    REG_ORIGIN_X   = 3'd3,
    REG_ORIGIN_Y   = 3'd4,
    REG_MIN_SCORE  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [15:0]        cell_value;
  } in_req_t;

  typedef struct packed {
    logic [15:0]      avg_score;
    logic [CNT_W-1:0] num_hits;
    logic             accepted;
  } out_res_t;

endpackage

// ===== rtl/scan_match_candidate_scorer.sv =====
// Top level of the scan match candidate scorer.
`timescale 1ns / 1ps
// Grid writes, point appends and scan clears are done when accepted. A
// score request walks the scan point memory one point per cycle (each
// point costs one point read and, in the cycle after it, one grid read),
// then runs a restoring divider, one quotient bit per cycle, and registers
// the result in its done state. The result appears on out_valid for exactly
// one cycle and cannot be held off, so the receiver must take it at once.
// busy stays high from acceptance of a score request until its result is
// shown.
module scan_match_candidate_scorer import smcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] grid_mem [MAP_DIM*MAP_DIM];
  logic [31:0] pt_mem   [MAX_POINTS];

  logic [8:0]  map_width_r, map_height_r;
  logic [2:0]  level_r;
  logic signed [15:0] origin_x_r, origin_y_r;
  logic [15:0] min_score_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] point_count_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic signed [15:0] cand_x_r, cand_y_r;
  logic             pt_vld_r;
  logic [31:0]      pt_q_r;
  logic             cell_vld_r;
  logic [15:0]      cell_q_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] hits_r;
  logic [SUM_W-1:0] quo_r;
  logic [SUM_W-1:0] rem_r;
  logic [5:0]       div_cnt_r;
  logic             out_valid_r;
  out_res_t         out_res_r;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
      level_r      <= 3'd0;
      origin_x_r   <= 16'sd0;
      origin_y_r   <= 16'sd0;
      min_score_r  <= 16'd19661;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  map_width_r  <= cfg_data[8:0];
        REG_MAP_HEIGHT: map_height_r <= cfg_data[8:0];
        REG_LEVEL:      level_r      <= cfg_data[2:0];
        REG_ORIGIN_X:   origin_x_r   <= cfg_data;
        REG_ORIGIN_Y:   origin_y_r   <= cfg_data;
        REG_MIN_SCORE:  min_score_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Point translation for the grid read.
  logic signed [19:0] tx, ty, pad, lim_x, lim_y;
  logic pt_in_range;
  always_comb begin
    pad   = 20'sd1 <<< level_r;
    pad   = pad - 20'sd1;
    lim_x = $signed({11'd0, map_width_r}) + pad;
    lim_y = $signed({11'd0, map_height_r}) + pad;
    tx = 20'(signed'(pt_q_r[15:0])) - 20'(origin_x_r) + 20'(cand_x_r) + pad;
    ty = 20'(signed'(pt_q_r[31:16])) - 20'(origin_y_r) + 20'(cand_y_r);
    pt_in_range = (tx >= 0) && (ty >= 0) && (tx < lim_x) && (ty < lim_y) &&
                  (tx < MAP_DIM) && (ty < MAP_DIM);
  end

  logic in_grid;
  logic [15:0] sat_val;
  assign in_grid = (in_req.coord_x >= 0) && (in_req.coord_y >= 0) &&
                   (in_req.coord_x < MAP_DIM) && (in_req.coord_y < MAP_DIM);
  assign sat_val = (in_req.cell_value > ONE_Q15) ? ONE_Q15 : in_req.cell_value;

  // Grid memory: write port for loads, read port for the walk.
  always_ff @(posedge clk) begin
    if (accept && in_req.action == ACT_WRITE_CELL && in_grid)
      grid_mem[{in_req.coord_y[CELL_AW-1:0], in_req.coord_x[CELL_AW-1:0]}] <= sat_val;
    cell_q_r <= grid_mem[{ty[CELL_AW-1:0], tx[CELL_AW-1:0]}];
  end

  // Point memory.
  always_ff @(posedge clk) begin
    if (accept && in_req.action == ACT_APPEND_PT && point_count_r < CNT_W'(MAX_POINTS))
      pt_mem[point_count_r[PT_AW-1:0]] <= {in_req.coord_y, in_req.coord_x};
    pt_q_r <= pt_mem[rd_idx_r[PT_AW-1:0]];
  end

  logic walk_issue;
  assign walk_issue = (state_r == ST_WALK) && (rd_idx_r < point_count_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_req.action == ACT_SCORE) state_nxt = ST_WALK;
      ST_WALK: if (!walk_issue && !pt_vld_r && !cell_vld_r) state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == 6'd0) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [SUM_W-1:0] rem_sh;
  logic [SUM_W:0]   rem_try;
  always_comb begin
    rem_sh  = {rem_r[SUM_W-2:0], quo_r[SUM_W-1]};
    rem_try = {1'b0, rem_sh} - {{(SUM_W+1-CNT_W){1'b0}}, hits_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      point_count_r <= '0;
      pt_vld_r      <= 1'b0;
      cell_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
      pt_vld_r    <= walk_issue;
      cell_vld_r  <= pt_vld_r && pt_in_range;
      if (accept && in_req.action == ACT_APPEND_PT && point_count_r < CNT_W'(MAX_POINTS))
        point_count_r <= point_count_r + 1'b1;
      if (accept && in_req.action == ACT_CLEAR_SCAN)
        point_count_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cand_x_r <= in_req.coord_x;
      cand_y_r <= in_req.coord_y;
      rd_idx_r <= '0;
      sum_r    <= '0;
      hits_r   <= '0;
    end
    if (walk_issue) rd_idx_r <= rd_idx_r + 1'b1;
    if (cell_vld_r && cell_q_r != UNKNOWN_CELL) begin
      sum_r  <= sum_r + SUM_W'(cell_q_r);
      hits_r <= hits_r + 1'b1;
    end
    if (state_r == ST_WALK) begin
      quo_r     <= sum_r;
      rem_r     <= '0;
      div_cnt_r <= 6'(SUM_W - 1);
    end
    if (state_r == ST_DIV) begin
      div_cnt_r <= div_cnt_r - 1'b1;
      if (!rem_try[SUM_W]) begin
        rem_r <= rem_try[SUM_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
    if (state_r == ST_DONE) begin
      out_res_r.avg_score <= (hits_r == '0) ? 16'd0 : quo_r[15:0];
      out_res_r.num_hits  <= hits_r;
      out_res_r.accepted  <= (hits_r != '0) &&
        (((CNT_W+7)'(hits_r) * (CNT_W+7)'(100)) >
         ((CNT_W+7)'(point_count_r) * (CNT_W+7)'(47))) &&
        (quo_r[15:0] > min_score_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== rtl/smcs_checker.sv =====
// Port checker for the scan match candidate scorer, bound to the top level.
`timescale 1ns / 1ps
module smcs_checker import smcs_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_req_t  in_req,
  input logic     out_valid,
  input out_res_t out_res
);

  a_score_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.action == ACT_SCORE |=> busy) else $error("no busy");

  a_other_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.action != ACT_SCORE |=> !busy) else $error("busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");

  a_acc_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.accepted |-> out_res.num_hits != 0) else $error("acc");

endmodule

bind scan_match_candidate_scorer smcs_checker u_smcs_checker (.*);
